[rtl/msss_pkg.sv]
// Package for the multi-stack shared store: sizes, payload structs, codes and
// pointer helpers. Depends on nothing; every other file imports it.
package msss_pkg;

  localparam int NumStacks = 4;
  localparam int Capacity  = 16;
  localparam int DataW     = 32;
  localparam int StackIdW  = 2;

  localparam int AddrW   = $clog2(Capacity);
  localparam int PtrW    = $clog2(Capacity + 1);
  localparam int TopIdxW = (NumStacks > 1) ? $clog2(NumStacks) : 1;

  typedef logic [AddrW-1:0] addr_t;
  typedef logic [PtrW-1:0]  ptr_t;

  // Null pointer is encoded as the slot count itself.
  localparam ptr_t NilPtr = PtrW'(Capacity);
  localparam logic signed [DataW-1:0] MaxPos = {1'b0, {(DataW - 1){1'b1}}};

  typedef enum logic [0:0] {
    CmdPush = 1'b0,
    CmdPop  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusOverflow  = 2'd1,
    StatusUnderflow = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    StateIdle = 1'b0,
    StateExec = 1'b1
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic [StackIdW-1:0]      stack_id;
    logic signed [DataW-1:0]  push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [DataW-1:0]  pop_value;
    status_e                  status;
  } out_item_t;

  function automatic logic ptr_valid(ptr_t p);
    return p < NilPtr;
  endfunction

  function automatic ptr_t clean_ptr(ptr_t p);
    return ptr_valid(p) ? p : NilPtr;
  endfunction

  // Reset chain: slot i links to i + 1, and the last slot to null.
  function automatic ptr_t init_link(addr_t a);
    return PtrW'(a) + PtrW'(1);
  endfunction

  function automatic logic stack_in_range(logic [StackIdW-1:0] sid);
    return int'(sid) < NumStacks;
  endfunction

endpackage

[rtl/multi_stack_shared_store.sv]
// Several LIFO stacks sharing one slot store, chained through a free list.
// Uses msss_pkg, msss_link_store and msss_data_store.
//
// Each input item is a push or a pop on one stack and yields exactly one
// result item with a value and a status (ok, overflow, underflow). A push
// onto a full store, or a pop from an empty stack, changes nothing and
// its result is registered at the accepting edge. In a successful
// operation, the link of the chosen slot is read from the link memory at
// the accepting edge (registered read), and at the next edge the
// free-list head, the stack top and the link are written back. The block
// accepts a new item only in its idle state, so it takes no new item
// until a successful one has been written back.
// The output register lets an item be accepted while the previous result
// is still waiting, as long as that result leaves at the same edge. The
// link memory tracks written slots with one flag per slot, so after reset
// no clearing pass is needed and the block is ready at once.
module multi_stack_shared_store (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  msss_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output msss_pkg::out_item_t out_item_o
);
  import msss_pkg::*;

  state_e state_q, state_d;

  ptr_t      free_head_q, free_head_d;
  ptr_t      top_q [NumStacks];
  ptr_t      top_d [NumStacks];

  // Operation held between the read and the write-back cycle.
  cmd_e         op_cmd_q;
  logic [TopIdxW-1:0] op_sid_q;
  addr_t        op_slot_q;

  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  logic in_accept;
  logic out_free;
  logic item_ok;
  logic [TopIdxW-1:0] in_sid;
  ptr_t sel_top;
  ptr_t in_slot;

  logic  link_rd_en;
  ptr_t  link_rd_data;
  logic  link_wr_en;
  ptr_t  link_wr_data;
  ptr_t  link_next;

  logic  data_rd_en;
  logic  data_wr_en;
  logic signed [DataW-1:0] data_rd_data;

  // The output register is free when empty or when its item leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != StateIdle) || !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_sid  = TopIdxW'(in_item_i.stack_id);
  assign sel_top = top_q[in_sid];

  // A push takes the free-list head, a pop takes the stack's top slot.
  always_comb begin
    if (in_item_i.cmd == CmdPush) begin
      in_slot = free_head_q;
    end else begin
      in_slot = sel_top;
    end
  end

  assign item_ok = stack_in_range(in_item_i.stack_id) && ptr_valid(in_slot);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StateIdle: begin
        if (in_accept && item_ok) begin
          state_d = StateExec;
        end
      end
      StateExec: begin
        state_d = StateIdle;
      end
      default: begin
        state_d = StateIdle;
      end
    endcase
  end

  assign link_next = clean_ptr(link_rd_data);

  // Memory accesses, pointer updates and result generation.
  always_comb begin
    free_head_d  = free_head_q;
    top_d        = top_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_item_d   = out_item_q;
    link_rd_en   = 1'b0;
    link_wr_en   = 1'b0;
    link_wr_data = free_head_q;
    data_rd_en   = 1'b0;
    data_wr_en   = 1'b0;

    unique case (state_q)
      StateIdle: begin
        if (in_accept) begin
          if (item_ok) begin
            // Fetch the slot's link; a push stores its value right away,
            // a pop reads the value it will return.
            link_rd_en = 1'b1;
            data_wr_en = (in_item_i.cmd == CmdPush);
            data_rd_en = (in_item_i.cmd == CmdPop);
          end else begin
            out_valid_d = 1'b1;
            if (in_item_i.cmd == CmdPush) begin
              out_item_d.pop_value = '0;
              out_item_d.status    = StatusOverflow;
            end else begin
              out_item_d.pop_value = MaxPos;
              out_item_d.status    = StatusUnderflow;
            end
          end
        end
      end
      StateExec: begin
        link_wr_en  = 1'b1;
        out_valid_d = 1'b1;
        out_item_d.status = StatusOk;
        if (op_cmd_q == CmdPush) begin
          // Slot leaves the free list and goes on top of the stack.
          free_head_d          = link_next;
          link_wr_data         = top_q[op_sid_q];
          top_d[op_sid_q]      = PtrW'(op_slot_q);
          out_item_d.pop_value = '0;
        end else begin
          // Slot leaves the stack and goes to the front of the free list.
          top_d[op_sid_q]      = link_next;
          link_wr_data         = free_head_q;
          free_head_d          = PtrW'(op_slot_q);
          out_item_d.pop_value = data_rd_data;
        end
      end
      default: begin
        out_valid_d = out_valid_q && out_stall_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      free_head_q <= '0;
      for (int i = 0; i < NumStacks; i++) begin
        top_q[i] <= NilPtr;
      end
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (in_accept) begin
      op_cmd_q  <= in_item_i.cmd;
      op_sid_q  <= in_sid;
      op_slot_q <= AddrW'(in_slot);
    end
  end

  msss_link_store u_link_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (link_rd_en),
    .rd_addr_i (AddrW'(in_slot)),
    .rd_data_o (link_rd_data),
    .wr_en_i   (link_wr_en),
    .wr_addr_i (op_slot_q),
    .wr_data_i (link_wr_data)
  );

  msss_data_store u_data_store (
    .clk_i     (clk_i),
    .rd_en_i   (data_rd_en),
    .rd_addr_i (AddrW'(in_slot)),
    .rd_data_o (data_rd_data),
    .wr_en_i   (data_wr_en),
    .wr_addr_i (AddrW'(in_slot)),
    .wr_data_i (in_item_i.push_value)
  );

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

[rtl/msss_link_store.sv]
// Link memory of the multi-stack shared store, one next-pointer per slot.
// Uses msss_pkg; written slots are tracked so unwritten ones read the reset chain.
module msss_link_store (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  msss_pkg::addr_t rd_addr_i,
  output msss_pkg::ptr_t  rd_data_o,
  input  logic          wr_en_i,
  input  msss_pkg::addr_t wr_addr_i,
  input  msss_pkg::ptr_t  wr_data_i
);
  import msss_pkg::*;

  ptr_t                mem [Capacity];
  logic [Capacity-1:0] written_q;
  ptr_t                rd_data_q;
  logic                rd_hit_q;
  addr_t               rd_addr_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rd_hit_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_hit_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_hit_q ? rd_data_q : init_link(rd_addr_q);

endmodule

[rtl/msss_data_store.sv]
// Value memory of the multi-stack shared store, one data word per slot.
// Uses msss_pkg for sizes; read data is registered.
module msss_data_store (
  input  logic                             clk_i,
  input  logic                             rd_en_i,
  input  msss_pkg::addr_t                  rd_addr_i,
  output logic signed [msss_pkg::DataW-1:0] rd_data_o,
  input  logic                             wr_en_i,
  input  msss_pkg::addr_t                  wr_addr_i,
  input  logic signed [msss_pkg::DataW-1:0] wr_data_i
);
  import msss_pkg::*;

  logic signed [DataW-1:0] mem [Capacity];
  logic signed [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/msss_checker.sv]
// Port-level checks for the multi-stack shared store, bound to the top level.
// Uses msss_pkg for the payload types and status codes.
module msss_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input msss_pkg::in_item_t  in_item_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input msss_pkg::out_item_t out_item_o
);
  import msss_pkg::*;

  // A stalled result stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or vanished");

  // After an accepted item, either its result is shown or the block is busy.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o || in_stall_o)
    else $error("accepted item neither answered nor in progress");

  // An overflow answer carries a zero value.
  a_overflow_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == StatusOverflow |-> out_item_o.pop_value == '0)
    else $error("overflow result with nonzero value");

  // An underflow answer carries the largest positive value.
  a_underflow_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == StatusUnderflow |-> out_item_o.pop_value == MaxPos)
    else $error("underflow result with wrong value");

endmodule

bind multi_stack_shared_store msss_checker u_msss_checker (.*);
